/* rtl/led_pattern_and_beep_timer_top_assert.svh */
// ----------------------------------------------------------------------------
// led pattern and beep timer assertion macros
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_AND_BEEP_TIMER_TOP_ASSERT_SVH
`define LED_PATTERN_AND_BEEP_TIMER_TOP_ASSERT_SVH

// property checked at every clock edge outside reset
`define LPBT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpbt assertion failed");

// condition in one cycle implies expression in the next
`define LPBT_ASSERT_NEXT(lbl, cond, expr) \
    `LPBT_ASSERT(lbl, (cond) |=> (expr))

`endif

/* rtl/lpbt_pkg.sv */
// ----------------------------------------------------------------------------
// lpbt_pkg
// types, constants and constant tables of the led pattern and beep timer
// ----------------------------------------------------------------------------
`default_nettype none

package lpbt_pkg;

    localparam int ELAPSED_WIDTH = 32;

    localparam int OPCODE_W = 3;
    localparam int PERIOD_W = 16;
    localparam int MODE_W   = 3;
    localparam int BEEP_W   = 16;

    localparam int S_TDATA_W = ((OPCODE_W + PERIOD_W + MODE_W + BEEP_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    localparam int PH1000_W = 10;
    localparam int PH1200_W = 11;

    // period split into a table-reduced high byte and a raw low byte
    localparam int LO_W     = 8;
    localparam int LO_SPAN  = 1 << LO_W;
    localparam int HI_DEPTH = 1 << (PERIOD_W - LO_W);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK     = 3'd0,
        OP_SET_MODE = 3'd1,
        OP_BUZZ_ON  = 3'd2,
        OP_BUZZ_OFF = 3'd3,
        OP_BEEP     = 3'd4
    } op_t;

    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BUSY  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRACK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RC    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAULT = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_LED_POL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUZ_POL = 1'd1;

    localparam int TRACK_PERIOD    = 1000;
    localparam int TRACK_ON        = 500;
    localparam int RC_PERIOD       = 250;
    localparam int RC_ON           = 125;
    localparam int FAULT_PERIOD    = 1200;
    localparam int FAULT_ON1_END   = 200;
    localparam int FAULT_ON2_START = 400;
    localparam int FAULT_ON2_END   = 600;

    // 2^ELAPSED_WIDTH reduced by a modulus, by repeated doubling
    function automatic int pow2_mod(int m);
        int r;
        r = 1;
        for (int i = 0; i < ELAPSED_WIDTH; i++)
        begin
            r = r * 2;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r;
    endfunction

    localparam int WRAP_1000 = pow2_mod(TRACK_PERIOD);
    localparam int WRAP_1200 = pow2_mod(FAULT_PERIOD);

    typedef logic [HI_DEPTH-1:0][PH1200_W-1:0] hi_lut_t;

    // entry i holds (i * LO_SPAN) reduced by the modulus
    function automatic hi_lut_t build_hi_lut(int m);
        hi_lut_t t;
        int      acc;
        acc = 0;
        for (int i = 0; i < HI_DEPTH; i++)
        begin
            t[i] = PH1200_W'(acc);
            acc  = acc + LO_SPAN;
            if (acc >= m)
            begin
                acc = acc - m;
            end
        end
        return t;
    endfunction

    localparam hi_lut_t HI_MOD_1000 = build_hi_lut(TRACK_PERIOD);
    localparam hi_lut_t HI_MOD_1200 = build_hi_lut(FAULT_PERIOD);

    typedef struct packed {
        logic [PH1000_W-1:0] pm1000;
        logic [PH1200_W-1:0] pm1200;
    } period_mod_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PERIOD_W-1:0] period;
        logic [MODE_W-1:0]   mode;
        logic [BEEP_W-1:0]   beep;
        period_mod_t         pm;
    } item_t;

endpackage

`default_nettype wire

/* rtl/lpbt_period_mod.sv */
// ----------------------------------------------------------------------------
// lpbt_period_mod
// reduces a tick period modulo the 1000 ms and 1200 ms pattern cycles
// ----------------------------------------------------------------------------
`default_nettype none

module lpbt_period_mod
    import lpbt_pkg::*;
(
    input  wire logic [PERIOD_W-1:0] period,
    output period_mod_t              pm
);

    logic [PERIOD_W-LO_W-1:0] hi;
    logic [LO_W-1:0]          lo;
    logic [PH1200_W:0]        sum1000;
    logic [PH1200_W:0]        sum1200;

    assign hi = period[PERIOD_W-1:LO_W];
    assign lo = period[LO_W-1:0];

    assign sum1000 = {1'b0, HI_MOD_1000[hi]} + (PH1200_W+1)'(lo);
    assign sum1200 = {1'b0, HI_MOD_1200[hi]} + (PH1200_W+1)'(lo);

    always_comb
    begin
        if (sum1000 >= (PH1200_W+1)'(TRACK_PERIOD))
        begin
            pm.pm1000 = PH1000_W'(sum1000 - (PH1200_W+1)'(TRACK_PERIOD));
        end
        else
        begin
            pm.pm1000 = PH1000_W'(sum1000);
        end
        if (sum1200 >= (PH1200_W+1)'(FAULT_PERIOD))
        begin
            pm.pm1200 = PH1200_W'(sum1200 - (PH1200_W+1)'(FAULT_PERIOD));
        end
        else
        begin
            pm.pm1200 = PH1200_W'(sum1200);
        end
    end

endmodule

`default_nettype wire

/* rtl/led_pattern_and_beep_timer_top.sv */
// ----------------------------------------------------------------------------
// led_pattern_and_beep_timer_top
// heartbeat led pattern generator with a timed buzzer
// ----------------------------------------------------------------------------
// One transaction is taken per clock unless the output stalls, and every
// transaction yields one result with the led and buzzer pin levels. The
// input register holds a taken item with its period already reduced modulo
// 1000 ms and 1200 ms through small constant tables, and the result register
// follows a single pass of state update logic. The pattern phase is kept as
// running remainders instead of dividing the elapsed counter, so the
// sustained rate is one item per cycle unless the output stalls. Polarity
// registers are written on the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_and_beep_timer_top
    import lpbt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode, tick_period_ms, new_mode, beep_length_ms, zero pad
    input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // led_level, buzzer_level, zero pad
    output logic [M_TDATA_W-1:0]        m_axis_tdata,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int OP_LSB   = 0;
    localparam int PER_LSB  = OP_LSB + OPCODE_W;
    localparam int MODE_LSB = PER_LSB + PERIOD_W;
    localparam int BEEP_LSB = MODE_LSB + MODE_W;

    // configuration
    logic led_pol_reg;
    logic buz_pol_reg;

    // pipeline
    item_t       item_in;
    item_t       s1_item_reg;
    logic        s1_valid_reg;
    logic        out_valid_reg;
    logic [1:0]  out_data_reg;
    logic [1:0]  out_data_next;
    logic        advance;
    logic        s_accept;

    // block state
    logic [MODE_W-1:0]        mode_reg,     mode_next;
    logic [ELAPSED_WIDTH-1:0] elapsed_reg,  elapsed_next;
    logic [PH1000_W-1:0]      ph1000_reg,   ph1000_next;
    logic [PH1200_W-1:0]      ph1200_reg,   ph1200_next;
    logic [BEEP_W-1:0]        beep_rem_reg, beep_rem_next;
    logic                     lit_reg,      lit_next;
    logic                     sound_reg,    sound_next;

    // tick datapath
    logic [ELAPSED_WIDTH:0]   elapsed_sum;
    logic                     wrap;
    logic [PH1000_W:0]        add1000;
    logic [PH1200_W:0]        add1200;
    logic [PH1000_W-1:0]      red1000;
    logic [PH1200_W-1:0]      red1200;
    logic [PH1000_W-1:0]      tick1000;
    logic [PH1200_W-1:0]      tick1200;
    logic [PH1000_W-1:0]      ph250;
    logic                     tick_lit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_pol_reg <= 1'b1;
            buz_pol_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LED_POL: led_pol_reg <= cfg_data[0];
                CFG_BUZ_POL: buz_pol_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign item_in.opcode = s_axis_tdata[PER_LSB-1:OP_LSB];
    assign item_in.period = s_axis_tdata[MODE_LSB-1:PER_LSB];
    assign item_in.mode   = s_axis_tdata[BEEP_LSB-1:MODE_LSB];
    assign item_in.beep   = s_axis_tdata[BEEP_LSB+BEEP_W-1:BEEP_LSB];

    lpbt_period_mod u_period_mod (
        .period (item_in.period),
        .pm     (item_in.pm)
    );

    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_item_reg <= item_in;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // elapsed counter and running phase remainders
    assign elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_WIDTH+1)'(s1_item_reg.period);
    assign wrap        = elapsed_sum[ELAPSED_WIDTH];
    assign add1000     = {1'b0, ph1000_reg} + {1'b0, s1_item_reg.pm.pm1000};
    assign add1200     = {1'b0, ph1200_reg} + {1'b0, s1_item_reg.pm.pm1200};

    always_comb
    begin
        if (add1000 >= (PH1000_W+1)'(TRACK_PERIOD))
        begin
            red1000 = PH1000_W'(add1000 - (PH1000_W+1)'(TRACK_PERIOD));
        end
        else
        begin
            red1000 = PH1000_W'(add1000);
        end
        if (add1200 >= (PH1200_W+1)'(FAULT_PERIOD))
        begin
            red1200 = PH1200_W'(add1200 - (PH1200_W+1)'(FAULT_PERIOD));
        end
        else
        begin
            red1200 = PH1200_W'(add1200);
        end

        // counter wrap drops 2^ELAPSED_WIDTH from the elapsed time
        tick1000 = red1000;
        tick1200 = red1200;
        if (wrap)
        begin
            if (red1000 >= PH1000_W'(WRAP_1000))
            begin
                tick1000 = red1000 - PH1000_W'(WRAP_1000);
            end
            else
            begin
                tick1000 = red1000 + PH1000_W'(TRACK_PERIOD - WRAP_1000);
            end
            if (red1200 >= PH1200_W'(WRAP_1200))
            begin
                tick1200 = red1200 - PH1200_W'(WRAP_1200);
            end
            else
            begin
                tick1200 = red1200 + PH1200_W'(FAULT_PERIOD - WRAP_1200);
            end
        end

        if (tick1000 >= PH1000_W'(3 * RC_PERIOD))
        begin
            ph250 = tick1000 - PH1000_W'(3 * RC_PERIOD);
        end
        else if (tick1000 >= PH1000_W'(2 * RC_PERIOD))
        begin
            ph250 = tick1000 - PH1000_W'(2 * RC_PERIOD);
        end
        else if (tick1000 >= PH1000_W'(RC_PERIOD))
        begin
            ph250 = tick1000 - PH1000_W'(RC_PERIOD);
        end
        else
        begin
            ph250 = tick1000;
        end

        case (mode_reg)
            MODE_BUSY:  tick_lit = 1'b1;
            MODE_TRACK: tick_lit = tick1000 < PH1000_W'(TRACK_ON);
            MODE_RC:    tick_lit = ph250 < PH1000_W'(RC_ON);
            MODE_FAULT: tick_lit = (tick1200 < PH1200_W'(FAULT_ON1_END)) ||
                                   ((tick1200 >= PH1200_W'(FAULT_ON2_START)) &&
                                    (tick1200 < PH1200_W'(FAULT_ON2_END)));
            default:    tick_lit = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        elapsed_next  = elapsed_reg;
        ph1000_next   = ph1000_reg;
        ph1200_next   = ph1200_reg;
        beep_rem_next = beep_rem_reg;
        lit_next      = lit_reg;
        sound_next    = sound_reg;
        case (s1_item_reg.opcode)
            OP_TICK:
            begin
                elapsed_next = elapsed_sum[ELAPSED_WIDTH-1:0];
                ph1000_next  = tick1000;
                ph1200_next  = tick1200;
                lit_next     = tick_lit;
                if (beep_rem_reg != '0)
                begin
                    if (beep_rem_reg <= s1_item_reg.period)
                    begin
                        beep_rem_next = '0;
                        sound_next    = 1'b0;
                    end
                    else
                    begin
                        beep_rem_next = beep_rem_reg - s1_item_reg.period;
                    end
                end
            end
            OP_SET_MODE:
            begin
                if (mode_reg != s1_item_reg.mode)
                begin
                    mode_next    = s1_item_reg.mode;
                    elapsed_next = '0;
                    ph1000_next  = '0;
                    ph1200_next  = '0;
                end
            end
            OP_BUZZ_ON:
            begin
                beep_rem_next = '0;
                sound_next    = 1'b1;
            end
            OP_BUZZ_OFF:
            begin
                beep_rem_next = '0;
                sound_next    = 1'b0;
            end
            OP_BEEP:
            begin
                beep_rem_next = s1_item_reg.beep;
                sound_next    = 1'b1;
            end
            default: ;
        endcase
    end

    assign out_data_next = {sound_next ^ ~buz_pol_reg, lit_next ^ ~led_pol_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OFF;
            elapsed_reg  <= '0;
            ph1000_reg   <= '0;
            ph1200_reg   <= '0;
            beep_rem_reg <= '0;
            lit_reg      <= 1'b0;
            sound_reg    <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            elapsed_reg  <= elapsed_next;
            ph1000_reg   <= ph1000_next;
            ph1200_reg   <= ph1200_next;
            beep_rem_reg <= beep_rem_next;
            lit_reg      <= lit_next;
            sound_reg    <= sound_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-2){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

/* rtl/lpbt_checker.sv */
// ----------------------------------------------------------------------------
// lpbt_checker
// port level checks of the led pattern and beep timer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_pattern_and_beep_timer_top_assert.svh"

module lpbt_checker
    import lpbt_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [M_TDATA_W-1:0]   m_axis_tdata
);

    logic       s_txn;
    logic       m_txn;
    logic [1:0] inflight_reg;

    assign s_txn = s_axis_tvalid && s_axis_tready;
    assign m_txn = m_axis_tvalid && m_axis_tready;

    // transactions taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else if (s_txn && !m_txn)
        begin
            inflight_reg <= inflight_reg + 2'd1;
        end
        else if (m_txn && !s_txn)
        begin
            inflight_reg <= inflight_reg - 2'd1;
        end
    end

    `LPBT_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `LPBT_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `LPBT_ASSERT(a_no_invented_result, m_axis_tvalid |-> (inflight_reg != 2'd0))
    `LPBT_ASSERT(a_full_blocks_input, (inflight_reg == 2'd2) && !m_axis_tready |-> !s_axis_tready)

endmodule

bind led_pattern_and_beep_timer_top lpbt_checker u_lpbt_checker (.*);

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the led pattern and beep timer
// ----------------------------------------------------------------------------
// A queue of commands feeds a stream driver. Each accepted transaction is run
// through a behavioral copy of the timer that tracks mode, elapsed phase and
// beep countdown. The pin levels it expects are kept in order and compared
// with every result taken on the output stream. A short directed opening
// covers the pattern edges, beep expiry and unknown codes. Random phases then
// run under several polarity settings, most of them with random stalls on
// both streams, and a closing phase runs with no idling at all. The driver
// holds off between phases until all results are back, and the polarity
// registers change only then.
// ----------------------------------------------------------------------------

module testbench
    import lpbt_pkg::*;
();

    localparam int CLK_HALF    = 4;
    localparam int RESET_TICKS = 11;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_TICKS = 10;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PERIOD_W-1:0] period;
        logic [MODE_W-1:0]   mode;
        logic [BEEP_W-1:0]   beep;
    } command_t;

    typedef struct packed {
        logic led;
        logic buzz;
    } pin_levels_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    command_t    command_q [$];
    pin_levels_t pin_levels_q [$];
    command_t    bus_cmd;
    logic        on_bus      = 1'b0;
    int          gap_left    = 0;
    int          stall_left  = 0;
    int          idle_pct    = 0;
    int          mismatches  = 0;
    int          cycle_count = 0;

    logic                     led_pol      = 1'b1;
    logic                     buz_pol      = 1'b1;
    logic [MODE_W-1:0]        pattern_sel  = MODE_OFF;
    logic [ELAPSED_WIDTH-1:0] phase_ms     = '0;
    logic [BEEP_W-1:0]        beep_left_ms = '0;
    logic                     lamp_on      = 1'b0;
    logic                     horn_on      = 1'b0;

    led_pattern_and_beep_timer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic pattern_lit(input logic [MODE_W-1:0] sel,
                                         input logic [ELAPSED_WIDTH-1:0] t);
        logic [ELAPSED_WIDTH-1:0] p;
        case (sel)
            MODE_BUSY:
                return 1'b1;
            MODE_TRACK:
                return (t % TRACK_PERIOD) < TRACK_ON;
            MODE_RC:
                return (t % RC_PERIOD) < RC_ON;
            MODE_FAULT:
            begin
                p = t % FAULT_PERIOD;
                return (p < FAULT_ON1_END) || (p >= FAULT_ON2_START && p < FAULT_ON2_END);
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic pin_levels_t apply_command(input command_t c);
        pin_levels_t r;
        case (c.opcode)
            OP_TICK:
            begin
                phase_ms = phase_ms + ELAPSED_WIDTH'(c.period);
                lamp_on  = pattern_lit(pattern_sel, phase_ms);
                if (beep_left_ms != '0)
                begin
                    if (beep_left_ms <= c.period)
                    begin
                        beep_left_ms = '0;
                        horn_on      = 1'b0;
                    end
                    else
                    begin
                        beep_left_ms = beep_left_ms - c.period;
                    end
                end
            end
            OP_SET_MODE:
            begin
                if (pattern_sel != c.mode)
                begin
                    pattern_sel = c.mode;
                    phase_ms    = '0;
                end
            end
            OP_BUZZ_ON:
            begin
                beep_left_ms = '0;
                horn_on      = 1'b1;
            end
            OP_BUZZ_OFF:
            begin
                beep_left_ms = '0;
                horn_on      = 1'b0;
            end
            OP_BEEP:
            begin
                beep_left_ms = c.beep;
                horn_on      = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.led  = led_pol ? lamp_on : ~lamp_on;
        r.buzz = buz_pol ? horn_on : ~horn_on;
        return r;
    endfunction

    function automatic command_t random_command();
        command_t c;
        int       pick;
        c.opcode = OP_TICK;
        c.period = PERIOD_W'($urandom);
        c.mode   = MODE_W'($urandom);
        c.beep   = BEEP_W'($urandom);
        pick     = $urandom_range(99);
        if (pick < 55)
        begin
            c.opcode = OP_TICK;
            if ($urandom_range(9) < 8)
            begin
                c.period = PERIOD_W'($urandom_range(700));
            end
        end
        else if (pick < 65)
        begin
            c.opcode = OP_SET_MODE;
            if ($urandom_range(9) < 8)
            begin
                c.mode = MODE_W'($urandom_range(MODE_FAULT));
            end
        end
        else if (pick < 72)
        begin
            c.opcode = OP_BUZZ_ON;
        end
        else if (pick < 79)
        begin
            c.opcode = OP_BUZZ_OFF;
        end
        else if (pick < 93)
        begin
            c.opcode = OP_BEEP;
            if ($urandom_range(9) < 8)
            begin
                c.beep = BEEP_W'($urandom_range(2500));
            end
        end
        else
        begin
            c.opcode = OPCODE_W'($urandom_range((1 << OPCODE_W) - 1, int'(OP_BEEP) + 1));
        end
        return c;
    endfunction

    task automatic queue_command(input logic [OPCODE_W-1:0] op,
                                 input logic [PERIOD_W-1:0] period,
                                 input logic [MODE_W-1:0]   mode,
                                 input logic [BEEP_W-1:0]   beep);
        command_t c;
        c.opcode = op;
        c.period = period;
        c.mode   = mode;
        c.beep   = beep;
        command_q.push_back(c);
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++)
        begin
            command_q.push_back(random_command());
        end
    endtask

    task automatic wait_drained();
        while (command_q.size() != 0 || on_bus || pin_levels_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // both registers written back to back while the block is idle
    task automatic write_polarity(input logic led_high, input logic buz_high);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LED_POL;
        cfg_data  <= led_high;
        do
            @(posedge clk);
        while (!cfg_ready);
        led_pol    = led_high;
        cfg_index <= CFG_BUZ_POL;
        cfg_data  <= buz_high;
        do
            @(posedge clk);
        while (!cfg_ready);
        buz_pol    = buz_high;
        cfg_valid <= 1'b0;
    endtask

    // stream driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            on_bus   = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pin_levels_q.push_back(apply_command(bus_cmd));
                on_bus = 1'b0;
            end
            if (!on_bus)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (command_q.size() != 0)
                begin
                    if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                    begin
                        gap_left = $urandom_range(8);
                    end
                    else
                    begin
                        bus_cmd = command_q.pop_front();
                        on_bus  = 1'b1;
                        s_axis_tdata <= S_TDATA_W'({bus_cmd.beep, bus_cmd.mode,
                                                    bus_cmd.period, bus_cmd.opcode});
                    end
                end
            end
            s_axis_tvalid <= on_bus;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        pin_levels_t want;
        logic        ready_next;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pin_levels_q.size() == 0)
                begin
                    $display("%0t: unexpected result, tdata %h", $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pin_levels_q.pop_front();
                    if (m_axis_tdata[0] !== want.led)
                    begin
                        $display("%0t: led_level expected %0b actual %0b",
                                 $time, want.led, m_axis_tdata[0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[1] !== want.buzz)
                    begin
                        $display("%0t: buzzer_level expected %0b actual %0b",
                                 $time, want.buzz, m_axis_tdata[1]);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                stall_left = $urandom_range(8);
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = 1'b1;
            end
            m_axis_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        idle_pct = 20;
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, unknown opcodes, pattern edges, beep expiry
        queue_command(OP_TICK, '0, '0, '0);
        queue_command(OPCODE_W'(int'(OP_BEEP) + 1), '1, '1, '1);
        queue_command({OPCODE_W{1'b1}}, '0, '0, '0);
        queue_command(OP_SET_MODE, '0, MODE_BUSY, '0);
        queue_command(OP_SET_MODE, '1, MODE_BUSY, '1);
        queue_command(OP_TICK, '0, '0, '0);
        queue_command(OP_SET_MODE, '0, MODE_TRACK, '0);
        queue_command(OP_TICK, PERIOD_W'(TRACK_ON - 1), '0, '0);
        queue_command(OP_TICK, PERIOD_W'(1), '0, '0);
        queue_command(OP_SET_MODE, '0, MODE_RC, '0);
        queue_command(OP_TICK, PERIOD_W'(RC_ON - 1), '0, '0);
        queue_command(OP_TICK, PERIOD_W'(1), '0, '0);
        queue_command(OP_SET_MODE, '0, MODE_FAULT, '0);
        queue_command(OP_TICK, PERIOD_W'(FAULT_ON1_END), '0, '0);
        queue_command(OP_TICK, PERIOD_W'(FAULT_ON2_START - FAULT_ON1_END), '0, '0);
        queue_command(OP_TICK, PERIOD_W'(FAULT_ON2_END - FAULT_ON2_START), '0, '0);
        queue_command(OP_SET_MODE, '0, {MODE_W{1'b1}}, '0);
        queue_command(OP_TICK, '1, '0, '0);
        queue_command(OP_BUZZ_ON, '0, '0, '0);
        queue_command(OP_TICK, '1, '0, '0);
        queue_command(OP_BEEP, '0, '0, '0);
        queue_command(OP_TICK, '1, '0, '0);
        queue_command(OP_BEEP, '0, '0, '1);
        queue_command(OP_TICK, '1, '0, '0);
        queue_command(OP_BUZZ_OFF, '0, '0, '0);
        queue_random(270);
        wait_drained();

        write_polarity(1'b0, 1'b0);
        idle_pct = 35;
        queue_random(270);
        wait_drained();

        write_polarity(1'b0, 1'b1);
        idle_pct = 10;
        queue_random(270);
        wait_drained();

        write_polarity(1'b1, 1'b0);
        idle_pct = 0;
        queue_random(270);
        wait_drained();

        write_polarity(1'b1, 1'b1);
        idle_pct = 15;
        queue_random(270);
        wait_drained();

        // closing run, no idling from here on
        write_polarity(1'b0, 1'b1);
        idle_pct = 0;
        queue_random(125);
        wait_drained();
        repeat (DRAIN_TICKS) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
